@@ design/assert_macros.svh @@
// Assertion macros for the RTL files (included by lru_page_tag_cache)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

@@ design/lptc_pkg.sv @@
// ---------------------------------------------------------------------------
// lptc_pkg
// Shared types and constants of the LRU page tag cache.
// ---------------------------------------------------------------------------
`default_nettype none
package lptc_pkg;
   localparam int unsigned DefaultEntries = 16;
   localparam logic [4:0] CapReset = 5'd16;

   typedef enum logic [1:0] {
      ACT_LOAD  = 2'd0,
      ACT_LOOK  = 2'd1,
      ACT_INS   = 2'd2,
      ACT_EVICT = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_HIT     = 3'd0,
      ST_LOADED  = 3'd1,
      ST_FAILED  = 3'd2,
      ST_ABSENT  = 3'd3,
      ST_INSERT  = 3'd4,
      ST_UPDATED = 3'd5,
      ST_EVICTED = 3'd6
   } status_type;

   // command broadcast from the controller to every cell
   typedef struct packed {
      logic        touch;   // move the matching entry to most recent
      logic        evict;   // drop the rank-zero entry, others move down
      logic        insert;  // first free cell takes the key
   } cell_cmd_type;
endpackage
`default_nettype wire

@@ design/lptc_cell.sv @@
// ---------------------------------------------------------------------------
// lptc_cell
// One table entry: key, valid bit and recency rank, with a free-slot chain.
// ---------------------------------------------------------------------------
`default_nettype none
module lptc_cell #(
   parameter int unsigned RW = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire lptc_pkg::cell_cmd_type cmd,
   input  wire logic [31:0]           key_file,
   input  wire logic [31:0]           key_page,
   input  wire logic [RW-1:0]         hit_rank,
   input  wire logic [RW-1:0]         top_rank,
   input  wire logic                  free_in,
   output logic                       free_out,
   output logic                       match,
   output logic                       oldest,
   output logic                       valid,
   output logic [31:0]                file_q,
   output logic [31:0]                page_q,
   output logic [RW-1:0]              rank_q
);
   logic          valid_ff, valid_in;
   logic [31:0]   file_ff, page_ff;
   logic [RW-1:0] rank_ff, rank_in;
   logic          take;

   assign valid    = valid_ff;
   assign file_q   = file_ff;
   assign page_q   = page_ff;
   assign rank_q   = rank_ff;
   assign match    = valid_ff && file_ff == key_file && page_ff == key_page;
   assign oldest   = valid_ff && rank_ff == '0;
   // a free cell takes the claim; an occupied cell passes it on
   assign take     = free_in && !valid_ff;
   assign free_out = free_in && valid_ff;

   // update rank and valid per command
   always_comb begin
      valid_in = valid_ff;
      rank_in  = rank_ff;
      if (cmd.touch && valid_ff) begin
         if (match) rank_in = top_rank;
         else if (rank_ff > hit_rank) rank_in = rank_ff - 1'b1;
      end
      if (cmd.evict && valid_ff) begin
         if (rank_ff == '0) valid_in = 1'b0;
         else rank_in = rank_ff - 1'b1;
      end
      if (cmd.insert && take) begin
         valid_in = 1'b1;
         rank_in  = top_rank;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      rank_ff <= rank_in;
      if (cmd.insert && take) begin
         file_ff <= key_file;
         page_ff <= key_page;
      end
   end
endmodule
`default_nettype wire

@@ design/lru_page_tag_cache.sv @@
// A request passes the decide, evict and done states; done registers the final result.
// One request at a time: req_tready is high only in the idle state.
// The controller evicts one entry per cycle while the output register is free.
// Reset (synchronous, active high) clears all valid bits, the count and
// sets capacity to 16; no clearing pass is needed.
// ---------------------------------------------------------------------------
// lru_page_tag_cache
// Fully associative LRU tag table built as a row of entry cells.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module lru_page_tag_cache #(
   parameter int unsigned ENTRIES = lptc_pkg::DefaultEntries
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // tdata: file_id[31:0], page_num[63:32], load_ok[64], target_count[69:65]
   input  wire logic [71:0] req_tdata,
   // tuser: action[1:0]
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // tdata: status[2:0], victim_file[34:3], victim_page[66:35], occupancy[71:67]
   output logic [71:0]      rsp_tdata,
   // tuser: report_kind
   output logic             rsp_tuser,
   output logic             rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic [4:0]  csr_wdata
);
   localparam int unsigned RW = $clog2(ENTRIES);
   localparam int unsigned CW = $clog2(ENTRIES + 1);

   typedef enum logic [1:0] {S_IDLE, S_DECIDE, S_EVICT, S_DONE} state_type;

   state_type   state_ff;
   logic [4:0]  cap_ff;
   logic [1:0]  act_ff;
   logic [31:0] file_ff, page_ff;
   logic        lok_ff;
   logic [4:0]  tgt_ff;
   logic [CW-1:0] cnt_ff;
   logic        hit_ff;
   logic [RW-1:0] hitrank_ff;
   logic        out_v_ff, out_k_ff, out_l_ff;
   logic [2:0]  out_st_ff;
   logic [31:0] out_vf_ff, out_vp_ff;
   logic [4:0]  out_occ_ff;

   lptc_pkg::cell_cmd_type cmd;
   logic [ENTRIES-1:0] match_v, oldest_v, valid_v;
   logic [ENTRIES:0]   free_c;
   logic [31:0] cf [ENTRIES];
   logic [31:0] cp [ENTRIES];
   logic [RW-1:0] top_rank;
   logic [RW-1:0] rank_of [ENTRIES];

   // row of entry cells; each reports its rank for the hit lookup
   assign free_c[0] = 1'b1;
   genvar g;
   for (g = 0; g < ENTRIES; g++) begin : g_cell
      lptc_cell #(.RW(RW)) u_cell (
         .clock, .reset, .cmd, .key_file(file_ff), .key_page(page_ff),
         .hit_rank(hitrank_ff), .top_rank, .free_in(free_c[g]),
         .free_out(free_c[g+1]), .match(match_v[g]), .oldest(oldest_v[g]),
         .valid(valid_v[g]), .file_q(cf[g]), .page_q(cp[g]),
         .rank_q(rank_of[g]));
   end

   // pick victim key and hit rank
   logic [31:0] vic_f, vic_p;
   logic        any_hit;
   logic [RW-1:0] h_rank;
   always_comb begin
      vic_f = '0; vic_p = '0; any_hit = 1'b0; h_rank = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (oldest_v[i]) begin vic_f = cf[i]; vic_p = cp[i]; end
         if (match_v[i]) begin any_hit = 1'b1; h_rank = rank_of[i]; end
      end
   end

   logic [CW-1:0] cap_eff;
   always_comb begin
      if (cap_ff == 5'd0) cap_eff = CW'(1);
      else if (32'(cap_ff) > ENTRIES) cap_eff = CW'(ENTRIES);
      else cap_eff = CW'(cap_ff);
   end

   logic need_evict;
   always_comb begin
      unique case (lptc_pkg::action_type'(act_ff))
         lptc_pkg::ACT_LOAD:  need_evict = !hit_ff && cnt_ff >= cap_eff && cnt_ff != '0;
         lptc_pkg::ACT_INS:   need_evict = !hit_ff && 32'(cnt_ff) >= ENTRIES;
         lptc_pkg::ACT_EVICT: need_evict = 32'(cnt_ff) > 32'(tgt_ff);
         default:             need_evict = 1'b0;
      endcase
   end

   logic out_free;
   assign out_free   = !out_v_ff || rsp_tready;
   assign req_tready = state_ff == S_IDLE;

   // load the output register with an eviction report or the final status
   logic out_load;
   assign out_load = out_free && ((state_ff == S_EVICT && need_evict) || state_ff == S_DONE);

   // cell commands
   always_comb begin
      cmd = '0;
      top_rank = RW'(cnt_ff - 1'b1);
      if (state_ff == S_EVICT && need_evict && out_free) cmd.evict = 1'b1;
      if (state_ff == S_DONE && out_free) begin
         if (hit_ff && (act_ff == lptc_pkg::ACT_LOAD || act_ff == lptc_pkg::ACT_INS))
            cmd.touch = 1'b1;
         if (!hit_ff && (act_ff == lptc_pkg::ACT_INS ||
                         (act_ff == lptc_pkg::ACT_LOAD && lok_ff))) begin
            cmd.insert = 1'b1;
            top_rank   = RW'(cnt_ff);
         end
      end
   end

   // occupancy after the final step of the request
   logic [CW-1:0] cnt_done;
   assign cnt_done = cnt_ff + CW'(cmd.insert);

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cap_ff   <= lptc_pkg::CapReset;
         cnt_ff   <= '0;
         out_v_ff <= 1'b0;
      end else begin
         if (csr_we) cap_ff <= csr_wdata;
         if (out_load) out_v_ff <= 1'b1;
         else if (rsp_tready) out_v_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (req_tvalid) begin
               act_ff  <= req_tuser;
               file_ff <= req_tdata[31:0];
               page_ff <= req_tdata[63:32];
               lok_ff  <= req_tdata[64];
               tgt_ff  <= req_tdata[69:65];
               state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               hit_ff     <= any_hit;
               hitrank_ff <= h_rank;
               state_ff   <= S_EVICT;
            end
            S_EVICT: if (!need_evict) begin
               state_ff <= S_DONE;
            end else if (out_free) begin
               out_k_ff   <= 1'b1;
               out_l_ff   <= 1'b0;
               out_st_ff  <= 3'd0;
               out_vf_ff  <= vic_f;
               out_vp_ff  <= vic_p;
               out_occ_ff <= 5'(cnt_ff - 1'b1);
               cnt_ff     <= cnt_ff - 1'b1;
            end
            S_DONE: if (out_free) begin
               out_k_ff  <= 1'b0;
               out_l_ff  <= 1'b1;
               out_vf_ff <= '0;
               out_vp_ff <= '0;
               out_occ_ff <= 5'(cnt_done);
               cnt_ff    <= cnt_done;
               state_ff  <= S_IDLE;
               unique case (lptc_pkg::action_type'(act_ff))
                  lptc_pkg::ACT_LOAD: begin
                     if (hit_ff) out_st_ff <= lptc_pkg::ST_HIT;
                     else if (lok_ff) out_st_ff <= lptc_pkg::ST_LOADED;
                     else out_st_ff <= lptc_pkg::ST_FAILED;
                  end
                  lptc_pkg::ACT_LOOK:
                     out_st_ff <= hit_ff ? lptc_pkg::ST_HIT : lptc_pkg::ST_ABSENT;
                  lptc_pkg::ACT_INS:
                     out_st_ff <= hit_ff ? lptc_pkg::ST_UPDATED : lptc_pkg::ST_INSERT;
                  default: out_st_ff <= lptc_pkg::ST_EVICTED;
               endcase
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tuser  = out_k_ff;
   assign rsp_tlast  = out_l_ff;
   assign rsp_tdata  = {out_occ_ff, out_vp_ff, out_vf_ff, out_st_ff};

   `ASSERT_CLK(a_count_matches, clock, reset, 32'($countones(valid_v)) == 32'(cnt_ff) || state_ff != S_IDLE, "valid count mismatch")
   `ASSERT_CLK(a_one_match, clock, reset, $onehot0(match_v), "duplicate key in table")
   `ASSERT_CLK(a_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata), "result changed while stalled")
endmodule
`default_nettype wire
